FILE: sv/bts_pkg.sv
// Package for the best-times sorted insert core.
// Holds field widths, request codes, the entry and link types, and the total-seconds function.
// No dependencies.
package bts_pkg;

    localparam int HOURS_W   = 8;
    localparam int MIN_W     = 6;
    localparam int SEC_W     = 6;
    localparam int TAG_W     = 16;
    localparam int IDX_W     = 6;
    localparam int CNT_OUT_W = 7;
    localparam int TOTAL_W   = 20;  // 255*3600 + 63*60 + 63 fits in 20 bits

    localparam int SEC_PER_HOUR = 3600;
    localparam int SEC_PER_MIN  = 60;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 56;

    typedef enum logic {
        REQ_INSERT = 1'b0,
        REQ_READ   = 1'b1
    } req_t;

    typedef struct packed {
        logic [HOURS_W-1:0] hours;
        logic [MIN_W-1:0]   minutes;
        logic [SEC_W-1:0]   seconds;
        logic [TAG_W-1:0]   tag;
        logic [TOTAL_W-1:0] total;
    } entry_t;

    // handed from each cell to the next one down the list
    typedef struct packed {
        logic take;   // new item belongs at or before this cell
        logic valid;
    } link_t;

    function automatic logic [TOTAL_W-1:0] total_of(input logic [HOURS_W-1:0] h,
                                                    input logic [MIN_W-1:0]   m,
                                                    input logic [SEC_W-1:0]   s);
        total_of = TOTAL_W'(h) * TOTAL_W'(SEC_PER_HOUR)
                 + TOTAL_W'(m) * TOTAL_W'(SEC_PER_MIN)
                 + TOTAL_W'(s);
    endfunction

endpackage

FILE: sv/bts_front.sv
// Input stage of the best-times core: registers one item and its total in seconds.
// Depends on bts_pkg.
module bts_front
    import bts_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // hours, minutes, seconds, tag, read_index
    input  logic                 s_tuser,   // req_type
    input  logic                 adv,
    output logic                 a_valid,
    output req_t                 a_req,
    output entry_t               a_entry,
    output logic [IDX_W-1:0]     a_read_index
);

    logic             valid_reg, valid_next;
    req_t             req_reg;
    entry_t           entry_reg;
    logic [IDX_W-1:0] ridx_reg;
    logic             accept;
    entry_t           in_entry;

    assign s_tready = !valid_reg || adv;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        in_entry.hours   = s_tdata[7:0];
        in_entry.minutes = s_tdata[13:8];
        in_entry.seconds = s_tdata[19:14];
        in_entry.tag     = s_tdata[35:20];
        in_entry.total   = total_of(s_tdata[7:0], s_tdata[13:8], s_tdata[19:14]);
    end

    always_comb begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = 1'b1;
        end else if (adv) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg   <= req_t'(s_tuser);
            entry_reg <= in_entry;
            ridx_reg  <= s_tdata[41:36];
        end
    end

    assign a_valid      = valid_reg;
    assign a_req        = req_reg;
    assign a_entry      = entry_reg;
    assign a_read_index = ridx_reg;

endmodule

FILE: sv/bts_cell.sv
// One list position of the best-times core: holds an entry, compares it with the new
// total and shifts from its upper neighbor on insert. Depends on bts_pkg.
module bts_cell
    import bts_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   upd,
    input  entry_t new_entry,
    input  link_t  prev_link,
    input  entry_t prev_entry,
    output link_t  link,
    output entry_t entry
);

    logic   valid_reg, valid_next;
    entry_t entry_reg, entry_next;
    logic   take;

    // empty cells always take; the valid prefix keeps take monotonic down the row
    assign take = !valid_reg || (new_entry.total < entry_reg.total);

    always_comb begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        if (upd) begin
            if (prev_link.take) begin
                valid_next = prev_link.valid;
                entry_next = prev_entry;
            end else if (take) begin
                valid_next = 1'b1;
                entry_next = new_entry;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign link.take  = take;
    assign link.valid = valid_reg;
    assign entry      = entry_reg;

endmodule

FILE: sv/best_times_sorted_insert_core.sv
// Best-times sorted insert core: a row of list cells keeping the shortest times in order.
// The result passes through the input register and then the output register.
// Throughput: one item per cycle unless the output stalls; each insert compares all cells with the new total at once.
// Reset (aresetn low, synchronous): clears the cell valid bits, the entry count and both
// pipeline valid flags; stored entries are not cleared.
module best_times_sorted_insert_core
    import bts_pkg::*;
#(
    parameter int TABLE_DEPTH = 10
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // hours[7:0], minutes[13:8], seconds[19:14],
                                            // tag[35:20], read_index[41:36]
    input  logic                 s_tuser,   // req_type
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // placed[0], place_index[6:1], entry_count[13:7],
                                            // entry_valid[14], hours[22:15], minutes[28:23],
                                            // seconds[34:29], tag[50:35]
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    logic             adv;
    logic             a_valid;
    req_t             a_req;
    entry_t           a_entry;
    logic [IDX_W-1:0] a_read_index;
    logic             do_item;
    logic             upd;
    link_t            head_link;

    link_t  link  [TABLE_DEPTH];
    entry_t ent   [TABLE_DEPTH];

    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0] out_data_reg, out_data_next;

    logic             placed;
    logic [IDX_W-1:0] place_idx;
    logic             rd_valid;
    entry_t           rd_entry;

    assign adv     = !out_valid_reg || m_tready;
    assign do_item = a_valid && adv;
    assign upd     = do_item && (a_req == REQ_INSERT);

    assign head_link.take  = 1'b0;
    assign head_link.valid = 1'b1;

    bts_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .adv          (adv),
        .a_valid      (a_valid),
        .a_req        (a_req),
        .a_entry      (a_entry),
        .a_read_index (a_read_index)
    );

    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        if (i == 0) begin : g_head
            bts_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .upd        (upd),
                .new_entry  (a_entry),
                .prev_link  (head_link),
                .prev_entry (a_entry),
                .link       (link[i]),
                .entry      (ent[i])
            );
        end else begin : g_body
            bts_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .upd        (upd),
                .new_entry  (a_entry),
                .prev_link  (link[i-1]),
                .prev_entry (ent[i-1]),
                .link       (link[i]),
                .entry      (ent[i])
            );
        end
    end

    // take is monotonic, so the last cell tells whether the item fits at all
    always_comb begin
        placed    = link[TABLE_DEPTH-1].take;
        place_idx = '0;
        rd_valid  = 1'b0;
        rd_entry  = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (link[i].take && ((i == 0) || !link[(i == 0) ? 0 : i-1].take)) begin
                place_idx = place_idx | IDX_W'(i);
            end
            if (link[i].valid && (a_read_index == IDX_W'(i))) begin
                rd_valid = 1'b1;
                rd_entry = rd_entry | ent[i];
            end
        end
    end

    always_comb begin
        count_next = count_reg;
        if (upd && placed && (count_reg < CNT_W'(TABLE_DEPTH))) begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_comb begin
        out_data_next = '0;
        out_data_next[13:7] = CNT_OUT_W'(count_next);
        if (a_req == REQ_INSERT) begin
            out_data_next[0]   = placed;
            out_data_next[6:1] = placed ? place_idx : '0;
        end else if (rd_valid) begin
            out_data_next[14]    = 1'b1;
            out_data_next[22:15] = rd_entry.hours;
            out_data_next[28:23] = rd_entry.minutes;
            out_data_next[34:29] = rd_entry.seconds;
            out_data_next[50:35] = rd_entry.tag;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (do_item) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_item) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

FILE: sv/bts_checker.sv
// Port-level checks for the best-times sorted insert core, bound to the top level.
// No package dependency.
module bts_checker #(
    parameter int TABLE_DEPTH = 10
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata
);

    // a stalled result item holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result item changed");

    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[13:7] <= 7'(TABLE_DEPTH))
        else $error("entry count above list depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[6:1] == 6'd0)
        else $error("place index without placement");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[14] |-> m_tdata[50:15] == 36'd0)
        else $error("entry fields set without valid entry");

endmodule

bind best_times_sorted_insert_core bts_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_bts_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
